[hw/rtl/dfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared constants, render mode codes and font lookup for the digit font row
// renderer.
// ----------------------------------------------------------------------------
package dfr_pkg;

  // default number of decimal digits kept per number
  localparam int MAX_DIGITS_DEF = 10;

  // rows per glyph and row index width
  localparam int ROWS  = 8;
  localparam int ROW_W = 3;

  // render mode codes
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_ITALIC   = 2'd1;
  localparam logic [1:0] MODE_MIRROR   = 2'd2;
  localparam logic [1:0] MODE_INVERTED = 2'd3;

  // reciprocal of ten, scaled by 2^35, exact for any 32-bit dividend
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  // all eight rows of one digit glyph, row 0 in the low byte
  function automatic logic [63:0] glyph_rows(input logic [3:0] digit);
    logic [63:0] g;
    unique case (digit)
      4'd0:    g = 64'h1824_2424_2424_1800;
      4'd1:    g = 64'h1818_1818_181c_1800;
      4'd2:    g = 64'h3e06_061c_3030_1e00;
      4'd3:    g = 64'h1e30_301c_3030_1e00;
      4'd4:    g = 64'h3030_3e32_3438_3000;
      4'd5:    g = 64'h1e30_3030_1e02_1e00;
      4'd6:    g = 64'h1c36_3636_1e06_1c00;
      4'd7:    g = 64'h0c0c_0c18_1830_3f00;
      4'd8:    g = 64'h1c36_361c_3636_1c00;
      4'd9:    g = 64'h1c30_3c36_3636_1c00;
      default: g = 64'h0;
    endcase
    return g;
  endfunction

  // one font byte for a digit and a font row
  function automatic logic [7:0] glyph_byte(input logic [3:0] digit,
                                            input logic [ROW_W-1:0] row);
    logic [63:0] g;
    g = glyph_rows(digit);
    return g[{row, 3'b000} +: 8];
  endfunction

  // bit reversal of a font byte
  function automatic logic [7:0] flip_byte(input logic [7:0] b);
    logic [7:0] r;
    for (int j = 0; j < 8; j++) begin
      r[7-j] = b[j];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/dfr_digit_split.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_digit_split
// Front end: accepts a number and mode, peels off one decimal digit per cycle
// and hands the digit set, in cell order, to the queue.
// ----------------------------------------------------------------------------
module dfr_digit_split
  import dfr_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int CW         = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [30:0]               in_number,
  input  wire logic [1:0]                in_render_mode,
  output logic                           push_valid,
  input  wire logic                      push_ready,
  output logic [MAX_DIGITS*4-1:0]        push_digits,
  output logic [CW-1:0]                  push_count,
  output logic [1:0]                     push_mode
);

  typedef enum logic {
    ST_IDLE,
    ST_SPLIT
  } state_t;

  state_t                         state_r, state_nxt;
  logic [30:0]                    val_r, val_nxt;
  logic [1:0]                     mode_r, mode_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [MAX_DIGITS-1:0][3:0]     digs_r, digs_nxt;

  logic                           done;
  logic [62:0]                    prod;
  logic [27:0]                    quot;
  logic [30:0]                    quot10;
  logic [30:0]                    rem;
  logic [3:0]                     dig;

  // divide by ten through the scaled reciprocal
  assign prod   = 63'(val_r) * 63'(DIV10_RECIP);
  assign quot   = prod[62:DIV10_SHIFT];
  assign quot10 = 31'({quot, 3'b000}) + 31'({quot, 1'b0});
  assign rem    = val_r - quot10;
  assign dig    = rem[3:0];

  // digit extraction ends on zero or when the cells are full
  assign done = (val_r == 31'd0) || (cnt_r == CW'(MAX_DIGITS));

  assign in_ready    = (state_r == ST_IDLE);
  assign push_valid  = (state_r == ST_SPLIT) && done;
  assign push_digits = digs_r;
  assign push_count  = cnt_r;
  assign push_mode   = mode_r;

  // next state and datapath
  always_comb begin
    state_nxt = state_r;
    val_nxt   = val_r;
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    digs_nxt  = digs_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SPLIT;
          val_nxt   = in_number;
          mode_nxt  = in_render_mode;
          cnt_nxt   = '0;
          digs_nxt  = '0;
        end
      end
      ST_SPLIT: begin
        if (done) begin
          if (push_ready) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          val_nxt = 31'(quot);
          cnt_nxt = cnt_r + CW'(1);
          if (mode_r == MODE_MIRROR) begin
            // least significant digit lands in cell 0
            for (int i = 0; i < MAX_DIGITS; i++) begin
              if (cnt_r == CW'(i)) begin
                digs_nxt[i] = dig;
              end
            end
          end else begin
            // shift up so the most significant digit ends in cell 0
            digs_nxt[0] = dig;
            for (int i = 1; i < MAX_DIGITS; i++) begin
              digs_nxt[i] = digs_r[i-1];
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    val_r  <= val_nxt;
    mode_r <= mode_nxt;
    cnt_r  <= cnt_nxt;
    digs_r <= digs_nxt;
  end

endmodule
`default_nettype wire

[hw/rtl/dfr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_queue
// Two-entry queue of digit sets between the front end and the row generator.
// ----------------------------------------------------------------------------
module dfr_queue
  import dfr_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int CW         = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push_valid,
  output logic                           push_ready,
  input  wire logic [MAX_DIGITS*4-1:0]   push_digits,
  input  wire logic [CW-1:0]             push_count,
  input  wire logic [1:0]                push_mode,
  output logic                           head_valid,
  input  wire logic                      head_pop,
  output logic [MAX_DIGITS*4-1:0]        head_digits,
  output logic [CW-1:0]                  head_count,
  output logic [1:0]                     head_mode
);

  logic [MAX_DIGITS*4-1:0] digits_r [2];
  logic [CW-1:0]           count_r  [2];
  logic [1:0]              mode_r   [2];
  logic                    wr_ptr_r, wr_ptr_nxt;
  logic                    rd_ptr_r, rd_ptr_nxt;
  logic [1:0]              fill_r, fill_nxt;
  logic                    do_push, do_pop;

  assign push_ready = (fill_r != 2'd2);
  assign head_valid = (fill_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = head_pop && head_valid;

  assign head_digits = digits_r[rd_ptr_r];
  assign head_count  = count_r[rd_ptr_r];
  assign head_mode   = mode_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      digits_r[wr_ptr_r] <= push_digits;
      count_r[wr_ptr_r]  <= push_count;
      mode_r[wr_ptr_r]   <= push_mode;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dfr_row_gen.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_row_gen
// Back end: walks the eight rows of the queue head, builds one pixel row per
// cycle from the font unless the output stalls, held in the output register.
// ----------------------------------------------------------------------------
module dfr_row_gen
  import dfr_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int CW         = $clog2(MAX_DIGITS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      head_valid,
  output logic                           head_pop,
  input  wire logic [MAX_DIGITS*4-1:0]   head_digits,
  input  wire logic [CW-1:0]             head_count,
  input  wire logic [1:0]                head_mode,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [63:0]                    out_pixels_low,
  output logic [15:0]                    out_pixels_high,
  output logic [3:0]                     out_cell_count,
  output logic [3:0]                     out_indent,
  output logic [2:0]                     out_font_row
  , output logic                         out_last_row
);

  logic              valid_r;
  logic [ROW_W-1:0]  row_r;
  logic [63:0]       pix_lo_r;
  logic [15:0]       pix_hi_r;
  logic [3:0]        count_r;
  logic [3:0]        indent_r;
  logic [ROW_W-1:0]  frow_r;
  logic              last_r;

  logic              advance;
  logic              last_row;
  logic [ROW_W-1:0]  frow;
  logic [79:0]       pix;
  logic [3:0]        indent;

  // a row moves whenever the head is valid and the output register is free or being taken
  assign advance  = head_valid && (!valid_r || out_ready);
  assign last_row = (row_r == ROW_W'(ROWS - 1));
  assign head_pop = advance && last_row;

  // inverted and mirror modes run bottom to top
  assign frow   = head_mode[1] ? ~row_r : row_r;
  assign indent = (head_mode == MODE_ITALIC) ? (4'd8 - 4'(frow)) : 4'd0;

  // one font byte per cell, blank past the digit count
  always_comb begin
    logic [7:0] b;
    pix = '0;
    for (int c = 0; c < MAX_DIGITS; c++) begin
      b = glyph_byte(head_digits[c*4 +: 4], frow);
      if (head_mode == MODE_MIRROR) begin
        b = flip_byte(b);
      end
      if (CW'(c) >= head_count) begin
        b = 8'h00;
      end
      pix[c*8 +: 8] = b;
    end
  end

  // row counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      row_r   <= '0;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        row_r   <= row_r + ROW_W'(1);
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      pix_lo_r <= pix[63:0];
      pix_hi_r <= pix[79:64];
      count_r  <= 4'(head_count);
      indent_r <= indent;
      frow_r   <= frow;
      last_r   <= last_row;
    end
  end

  assign out_valid       = valid_r;
  assign out_pixels_low  = pix_lo_r;
  assign out_pixels_high = pix_hi_r;
  assign out_cell_count  = count_r;
  assign out_indent      = indent_r;
  assign out_font_row    = frow_r;
  assign out_last_row    = last_r;

endmodule
`default_nettype wire

[hw/rtl/digit_font_row_renderer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// digit_font_row_renderer
// Splits a number into decimal digits and emits eight dot-matrix font rows
// per number, in one of four render modes.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   number, render_mode
//   out_     output     out_valid / out_ready pixels_low, pixels_high,
//                                             cell_count, indent, font_row,
//                                             last_row
//
// The front end does one divide by ten per cycle and takes a new number only
// once its last digit set is in the queue; the row generator builds one row
// per cycle while the output is not stalled, with a two-entry queue between.
// Synchronous active-low reset empties the queue and the output register.
// Either side may stall; stalls are absorbed by the queue and output register.
// ----------------------------------------------------------------------------
module digit_font_row_renderer
  import dfr_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [30:0] in_number,
  input  wire logic [1:0]  in_render_mode,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_pixels_low,
  output logic [15:0]      out_pixels_high,
  output logic [3:0]       out_cell_count,
  output logic [3:0]       out_indent,
  output logic [2:0]       out_font_row,
  output logic             out_last_row
);

  localparam int CW = $clog2(MAX_DIGITS + 1);

  logic                    push_valid, push_ready;
  logic [MAX_DIGITS*4-1:0] push_digits;
  logic [CW-1:0]           push_count;
  logic [1:0]              push_mode;
  logic                    head_valid, head_pop;
  logic [MAX_DIGITS*4-1:0] head_digits;
  logic [CW-1:0]           head_count;
  logic [1:0]              head_mode;

  // front end: digit extraction
  dfr_digit_split #(
    .MAX_DIGITS (MAX_DIGITS),
    .CW         (CW)
  ) u_split (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_number      (in_number),
    .in_render_mode (in_render_mode),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_digits    (push_digits),
    .push_count     (push_count),
    .push_mode      (push_mode)
  );

  // decoupling queue
  dfr_queue #(
    .MAX_DIGITS (MAX_DIGITS),
    .CW         (CW)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_digits (push_digits),
    .push_count  (push_count),
    .push_mode   (push_mode),
    .head_valid  (head_valid),
    .head_pop    (head_pop),
    .head_digits (head_digits),
    .head_count  (head_count),
    .head_mode   (head_mode)
  );

  // back end: row generation
  dfr_row_gen #(
    .MAX_DIGITS (MAX_DIGITS),
    .CW         (CW)
  ) u_rows (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_pop        (head_pop),
    .head_digits     (head_digits),
    .head_count      (head_count),
    .head_mode       (head_mode),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixels_low  (out_pixels_low),
    .out_pixels_high (out_pixels_high),
    .out_cell_count  (out_cell_count),
    .out_indent      (out_indent),
    .out_font_row    (out_font_row),
    .out_last_row    (out_last_row)
  );

endmodule
`default_nettype wire

[hw/rtl/dfr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfr_checker
// Port-level checks on the digit font row renderer, bound to the top level.
// ----------------------------------------------------------------------------
module dfr_checker
  import dfr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [30:0] in_number,
  input wire logic [1:0]  in_render_mode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_pixels_low,
  input wire logic [15:0] out_pixels_high,
  input wire logic [3:0]  out_cell_count,
  input wire logic [3:0]  out_indent,
  input wire logic [2:0]  out_font_row,
  input wire logic        out_last_row
);

  // a stalled result transaction holds its pixels, font row and last-row flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixels_low) &&
      $stable(out_pixels_high) && $stable(out_font_row) && $stable(out_last_row))
    else $error("result payload changed while stalled");

  // indent is zero or eight minus the font row
  a_indent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_indent == 4'd0) || (out_indent == 4'd8 - 4'(out_font_row)))
    else $error("indent does not match font row");

  // the final row is the bottom or top font row
  a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_row |-> (out_font_row == 3'd7) || (out_font_row == 3'd0))
    else $error("last row on an inner font row");

  // cells 8 and 9 stay blank when the count is at most eight
  a_blank_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_cell_count <= 4'd8) |-> (out_pixels_high == 16'd0))
    else $error("pixels beyond cell count");

  // cell count never exceeds the digit limit
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_count <= 4'(MAX_DIGITS_DEF)))
    else $error("cell count out of range");

endmodule

bind digit_font_row_renderer dfr_checker u_dfr_checker (.*);
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the digit font row renderer. Numbers and render
// modes go in over the in_ channel; a row predictor expands each accepted
// transaction into its eight expected font rows, and every row taken from
// the out_ channel is compared field by field with the oldest one waiting.
// Both sides idle and stall at random, with one stretch free of idling.
// ----------------------------------------------------------------------------
module tb_top;
  import dfr_pkg::*;

  localparam int DIGITS_KEPT = MAX_DIGITS_DEF;
  localparam int RANDOM_NUMBERS = 270;

  // one expected or observed output row, in port order
  typedef struct packed {
    logic [63:0] pix_lo;
    logic [15:0] pix_hi;
    logic [3:0]  cells;
    logic [3:0]  indent;
    logic [2:0]  frow;
    logic        last;
  } font_row_t;

  // --------------------------------------------------------------------------
  // row scoreboard: predicts the rows of a number and checks them in order
  // --------------------------------------------------------------------------
  class row_scoreboard;
    font_row_t pending_rows[$];
    int        errors = 0;

    // eight rows of a digit glyph, font row 0 in the low byte
    function logic [63:0] digit_glyph(input logic [3:0] d);
      logic [63:0] g;
      case (d)
        4'd0:    g = {8'h18, 8'h24, 8'h24, 8'h24, 8'h24, 8'h24, 8'h18, 8'h00};
        4'd1:    g = {8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h1c, 8'h18, 8'h00};
        4'd2:    g = {8'h3e, 8'h06, 8'h06, 8'h1c, 8'h30, 8'h30, 8'h1e, 8'h00};
        4'd3:    g = {8'h1e, 8'h30, 8'h30, 8'h1c, 8'h30, 8'h30, 8'h1e, 8'h00};
        4'd4:    g = {8'h30, 8'h30, 8'h3e, 8'h32, 8'h34, 8'h38, 8'h30, 8'h00};
        4'd5:    g = {8'h1e, 8'h30, 8'h30, 8'h30, 8'h1e, 8'h02, 8'h1e, 8'h00};
        4'd6:    g = {8'h1c, 8'h36, 8'h36, 8'h36, 8'h1e, 8'h06, 8'h1c, 8'h00};
        4'd7:    g = {8'h0c, 8'h0c, 8'h0c, 8'h18, 8'h18, 8'h30, 8'h3f, 8'h00};
        4'd8:    g = {8'h1c, 8'h36, 8'h36, 8'h1c, 8'h36, 8'h36, 8'h1c, 8'h00};
        default: g = {8'h1c, 8'h30, 8'h3c, 8'h36, 8'h36, 8'h36, 8'h1c, 8'h00};
      endcase
      return g;
    endfunction

    // expand an accepted number into its eight rows
    function void note_number(input logic [30:0] num, input logic [1:0] mode);
      logic [3:0]  digs [DIGITS_KEPT];
      int unsigned val;
      int          count;
      int          di;
      logic [2:0]  frow;
      logic [63:0] g;
      logic [7:0]  b;
      logic [7:0]  rev;
      logic [79:0] strip;
      font_row_t   row;
      val = num;
      count = 0;
      // split into decimal digits, least significant first
      while (val != 0 && count < DIGITS_KEPT) begin
        digs[count] = 4'(val % 10);
        val = val / 10;
        count++;
      end
      for (int r = 0; r < 8; r++) begin
        // mirror and inverted walk the glyph bottom to top
        if (mode == MODE_MIRROR || mode == MODE_INVERTED) frow = 3'(7 - r);
        else frow = 3'(r);
        strip = '0;
        for (int c = 0; c < count; c++) begin
          di = (mode == MODE_MIRROR) ? c : count - 1 - c;
          g = digit_glyph(digs[di]);
          b = g[{frow, 3'b000} +: 8];
          if (mode == MODE_MIRROR) begin
            for (int j = 0; j < 8; j++) rev[7 - j] = b[j];
            b = rev;
          end
          strip[c * 8 +: 8] = b;
        end
        row.pix_lo = strip[63:0];
        row.pix_hi = strip[79:64];
        row.cells  = 4'(count);
        row.indent = (mode == MODE_ITALIC) ? 4'(8 - frow) : 4'd0;
        row.frow   = frow;
        row.last   = (r == 7);
        pending_rows.push_back(row);
      end
    endfunction

    task report(input string what);
      if (errors < 100) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // compare one accepted row with the oldest expectation
    task check_row(input font_row_t got);
      font_row_t want;
      if (pending_rows.size() == 0) begin
        report($sformatf("row with nothing expected, font_row %0d", got.frow));
      end else begin
        want = pending_rows.pop_front();
        if (got.pix_lo !== want.pix_lo)
          report($sformatf("pixels_low exp %h got %h", want.pix_lo, got.pix_lo));
        if (got.pix_hi !== want.pix_hi)
          report($sformatf("pixels_high exp %h got %h", want.pix_hi, got.pix_hi));
        if (got.cells !== want.cells)
          report($sformatf("cell_count exp %0d got %0d", want.cells, got.cells));
        if (got.indent !== want.indent)
          report($sformatf("indent exp %0d got %0d", want.indent, got.indent));
        if (got.frow !== want.frow)
          report($sformatf("font_row exp %0d got %0d", want.frow, got.frow));
        if (got.last !== want.last)
          report($sformatf("last_row exp %0d got %0d", want.last, got.last));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [30:0] in_number = '0;
  logic [1:0]  in_render_mode = MODE_NORMAL;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_pixels_low;
  logic [15:0] out_pixels_high;
  logic [3:0]  out_cell_count;
  logic [3:0]  out_indent;
  logic [2:0]  out_font_row;
  logic        out_last_row;

  logic          no_idle = 1'b0;
  int            stall_left = 0;
  row_scoreboard sb;

  always #5 clk = ~clk;

  digit_font_row_renderer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_number       (in_number),
    .in_render_mode  (in_render_mode),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixels_low  (out_pixels_low),
    .out_pixels_high (out_pixels_high),
    .out_cell_count  (out_cell_count),
    .out_indent      (out_indent),
    .out_font_row    (out_font_row),
    .out_last_row    (out_last_row)
  );

  // pause length: mostly short, now and then long
  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random number with a spread of digit counts, zero now and then
  function automatic logic [30:0] pick_number();
    int          sel;
    int          len;
    longint      lo;
    longint      hi;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 20) return 31'($urandom);
    len = $urandom_range(1, 10);
    lo = 1;
    for (int k = 1; k < len; k++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'd2147483647) hi = 64'd2147483647;
    return 31'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  // --------------------------------------------------------------------------
  // monitors: note accepted numbers, check accepted rows
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_number(in_number, in_render_mode);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_row({out_pixels_low, out_pixels_high, out_cell_count, out_indent,
                    out_font_row, out_last_row});
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 99) < 25) begin
      out_ready  <= 1'b0;
      stall_left <= pick_pause() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks
  // --------------------------------------------------------------------------
  task automatic send_number(input logic [30:0] num, input logic [1:0] mode,
                             input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_number      <= num;
    in_render_mode <= mode;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every expected row has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_rows.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    logic [1:0] m;
    sb = new;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero, largest value and a full ten digits in every mode
    for (int k = 0; k < 4; k++) begin
      m = 2'(k);
      send_number(31'd0, m, 0);
      send_number(31'd2147483647, m, 0);
      send_number(31'd1234567890, m, 1);
    end
    // every digit glyph, single and mixed
    send_number(31'd1000000000, MODE_NORMAL, 0);
    send_number(31'd9, MODE_ITALIC, 0);
    send_number(31'd5, MODE_MIRROR, 2);
    send_number(31'd7, MODE_INVERTED, 0);
    send_number(31'd10, MODE_MIRROR, 0);
    send_number(31'd8, MODE_NORMAL, 0);
    send_number(31'd6, MODE_ITALIC, 0);
    send_number(31'd4, MODE_NORMAL, 5);
    send_number(31'd3, MODE_INVERTED, 0);
    send_number(31'd2, MODE_MIRROR, 0);
    send_number(31'd1, MODE_NORMAL, 0);
    send_number(31'd1999999999, MODE_MIRROR, 0);
    wait_drained();

    // random numbers, one stretch with no idling and one full drain
    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      no_idle <= (i >= 100 && i < 140);
      if (i == 200) wait_drained();
      if (no_idle || $urandom_range(0, 99) < 55) gap = 0;
      else gap = pick_pause();
      send_number(pick_number(), 2'($urandom_range(0, 3)), gap);
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (sb.pending_rows.size() != 0)
      sb.report($sformatf("%0d rows never came out", sb.pending_rows.size()));
    if (sb.errors == 0) begin
      $display("** digit_font_row_renderer: PASSED **");
    end else begin
      $display("** digit_font_row_renderer: FAILED **");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("** digit_font_row_renderer: FAILED **");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/dfr_pkg.sv
hw/rtl/dfr_digit_split.sv
hw/rtl/dfr_queue.sv
hw/rtl/dfr_row_gen.sv
hw/rtl/digit_font_row_renderer.sv
hw/rtl/dfr_checker.sv
test/tb_top.sv
